FILE: rtl/xrr_pkg.sv
// ----------------------------------------------------------------------------
// xrr_pkg
// Shared types and constants for the xorshift random block: kind codes,
// datapath command and status records, controller states and shift amounts.
// ----------------------------------------------------------------------------
package xrr_pkg;

    localparam int unsigned WORD_W = 32;

    // Xorshift shift amounts.
    localparam int unsigned XS_SHIFT_A = 15;
    localparam int unsigned XS_SHIFT_B = 21;
    localparam int unsigned XS_SHIFT_C = 4;

    // Seeds above this value use the halving chain.
    localparam logic [WORD_W-1:0] SEED_SPLIT = 32'd100;

    // Percent values at or above this always occur; also the percent scale.
    localparam logic [WORD_W-1:0] PCT_FULL  = 32'd100;
    localparam logic [WORD_W-1:0] PCT_SCALE = 32'd100;

    // Weights are clamped to WEIGHT_MIN..WEIGHT_MAX.
    localparam int unsigned WEIGHT_W = 7;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 7'd1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 7'd99;
    localparam int unsigned DIVISOR_W = WEIGHT_W + 1;

    // Restart chain offsets for words one, two and three.
    localparam logic [WORD_W-1:0] SEED_K1 = 32'd1;
    localparam logic [WORD_W-1:0] SEED_K2 = 32'd3;
    localparam logic [WORD_W-1:0] SEED_K3 = 32'd8;

    localparam int unsigned DIV_STEPS = WORD_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        KIND_RESTART  = 3'd0,
        KIND_RAW      = 3'd1,
        KIND_RANGE    = 3'd2,
        KIND_PERCENT  = 3'd3,
        KIND_WEIGHTED = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PREP,
        DP_SEED_LOAD,
        DP_SEED_STEP,
        DP_DRAW,
        DP_MUL,
        DP_ADD,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] seed_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       bounds_equal;
        logic       pct_zero;
        logic       pct_full;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEED_LOAD,
        ST_SEED_STEP,
        ST_DRAW,
        ST_MUL,
        ST_ADD,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH
    } state_t;

    function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [WORD_W-1:0] w);
        logic [WEIGHT_W-1:0] r;
        if (w < {{(WORD_W-WEIGHT_W){1'b0}}, WEIGHT_MIN}) begin
            r = WEIGHT_MIN;
        end else if (w > {{(WORD_W-WEIGHT_W){1'b0}}, WEIGHT_MAX}) begin
            r = WEIGHT_MAX;
        end else begin
            r = w[WEIGHT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] seed_offset(input logic [1:0] idx);
        logic [WORD_W-1:0] r;
        case (idx)
            2'd1:    r = SEED_K1;
            2'd2:    r = SEED_K2;
            2'd3:    r = SEED_K3;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/xrr_datapath.sv
// ----------------------------------------------------------------------------
// xrr_datapath
// Generator words, operand registers, shared multiplier, serial remainder
// unit and the result register. Driven one command per cycle by xrr_ctrl.
// ----------------------------------------------------------------------------
module xrr_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  xrr_pkg::dp_cmd_t           cmd,
    output xrr_pkg::dp_status_t        status,
    input  logic                       cfg_we,
    input  logic [31:0]                cfg_seed_value,
    input  logic [2:0]                 in_kind,
    input  logic [31:0]                in_first_operand,
    input  logic [31:0]                in_second_operand,
    output logic [31:0]                out_value,
    output logic                       out_occurs
);
    import xrr_pkg::*;

    logic [WORD_W-1:0]    w_reg [4];
    logic [WORD_W-1:0]    seed_reg;
    logic [2:0]           kind_reg;
    logic [WORD_W-1:0]    a_reg;
    logic [WORD_W-1:0]    b_reg;
    logic [WORD_W-1:0]    lo_reg;
    logic [WORD_W-1:0]    diff_reg;
    logic [38:0]          rhs_reg;
    logic [WEIGHT_W-1:0]  wa_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic                 halve_reg;
    logic [WORD_W-1:0]    acc_reg;
    logic [63:0]          prod_reg;
    logic [63:0]          sum_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [WORD_W-1:0]    dividend_reg;
    logic [WORD_W-1:0]    value_reg;
    logic                 occurs_reg;

    logic [WORD_W-1:0]    t_word;
    logic [WORD_W-1:0]    draw_next;
    logic [WORD_W-1:0]    acc_next;
    logic [WORD_W-1:0]    mul_b;
    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_diff;
    logic                 a_less;
    logic [WEIGHT_W-1:0]  wb_clamped;
    logic [WEIGHT_W-1:0]  wa_clamped;
    logic [WORD_W-1:0]    value_next;
    logic                 occurs_next;

    assign status.kind         = kind_reg;
    assign status.bounds_equal = (a_reg == b_reg);
    assign status.pct_zero     = (a_reg == '0);
    assign status.pct_full     = (a_reg >= PCT_FULL);

    assign t_word    = w_reg[0] ^ (w_reg[0] << XS_SHIFT_A);
    assign draw_next = (w_reg[3] ^ (w_reg[3] >> XS_SHIFT_B)) ^ (t_word ^ (t_word >> XS_SHIFT_C));

    assign acc_next = halve_reg ? ((acc_reg >> 1) - seed_offset(cmd.seed_idx))
                                : ((acc_reg << 1) + seed_offset(cmd.seed_idx));

    assign mul_b = (kind_reg == KIND_RANGE) ? diff_reg : PCT_SCALE;

    assign rem_shift = {rem_reg, dividend_reg[WORD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    assign a_less     = (a_reg < b_reg);
    assign wa_clamped = clamp_weight(a_reg);
    assign wb_clamped = clamp_weight(b_reg);

    always_comb begin
        value_next  = '0;
        occurs_next = 1'b0;
        case (kind_reg)
            KIND_RAW: begin
                value_next = w_reg[3];
            end
            KIND_RANGE: begin
                value_next = status.bounds_equal ? a_reg : (lo_reg + sum_reg[63:32]);
            end
            KIND_PERCENT: begin
                if (status.pct_zero) begin
                    occurs_next = 1'b0;
                end else if (status.pct_full) begin
                    occurs_next = 1'b1;
                end else begin
                    occurs_next = (prod_reg <= {25'd0, rhs_reg});
                end
            end
            KIND_WEIGHTED: begin
                // (word mod (A+B)) + 1 <= A is the same as remainder < A.
                occurs_next = (rem_reg < {1'b0, wa_reg});
            end
            default: begin
                value_next  = '0;
                occurs_next = 1'b0;
            end
        endcase
    end

    // Generator words and the configured seed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                w_reg[i] <= '0;
            end
            seed_reg <= '0;
        end else begin
            if (cfg_we) begin
                seed_reg <= cfg_seed_value;
            end
            case (cmd.op)
                DP_SEED_LOAD: begin
                    w_reg[0] <= seed_reg;
                end
                DP_SEED_STEP: begin
                    w_reg[cmd.seed_idx] <= acc_next;
                end
                DP_DRAW: begin
                    w_reg[0] <= w_reg[1];
                    w_reg[1] <= w_reg[2];
                    w_reg[2] <= w_reg[3];
                    w_reg[3] <= draw_next;
                end
                default: begin
                end
            endcase
        end
    end

    // Operand, arithmetic and result registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                kind_reg <= in_kind;
                a_reg    <= in_first_operand;
                b_reg    <= in_second_operand;
            end
            DP_PREP: begin
                lo_reg      <= a_less ? a_reg : b_reg;
                diff_reg    <= a_less ? (b_reg - a_reg) : (a_reg - b_reg);
                // p * (2^32 - 1) for 1 <= p <= 99, split into its two halves.
                rhs_reg     <= {a_reg[6:0] - 7'd1, (~a_reg) + 32'd1};
                wa_reg      <= wa_clamped;
                divisor_reg <= {1'b0, wa_clamped} + {1'b0, wb_clamped};
            end
            DP_SEED_LOAD: begin
                acc_reg   <= seed_reg;
                halve_reg <= (seed_reg > SEED_SPLIT);
            end
            DP_SEED_STEP: begin
                acc_reg <= acc_next;
            end
            DP_MUL: begin
                prod_reg <= w_reg[3] * mul_b;
            end
            DP_ADD: begin
                // word * (diff + 1) without a 33-bit multiplier operand.
                sum_reg <= prod_reg + {32'd0, w_reg[3]};
            end
            DP_DIV_INIT: begin
                rem_reg      <= '0;
                dividend_reg <= w_reg[3];
            end
            DP_DIV_STEP: begin
                rem_reg      <= rem_diff[DIVISOR_W] ? rem_shift[DIVISOR_W-1:0]
                                                    : rem_diff[DIVISOR_W-1:0];
                dividend_reg <= dividend_reg << 1;
            end
            DP_RESULT: begin
                value_reg  <= value_next;
                occurs_reg <= occurs_next;
            end
            default: begin
            end
        endcase
    end

    assign out_value  = value_reg;
    assign out_occurs = occurs_reg;

endmodule

FILE: rtl/xrr_ctrl.sv
// ----------------------------------------------------------------------------
// xrr_ctrl
// Sequencer for the xorshift random block. Owns the input and result
// handshakes and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module xrr_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output xrr_pkg::dp_cmd_t        cmd,
    input  xrr_pkg::dp_status_t     status
);
    import xrr_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             m_valid_reg;
    logic             m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd.op       = DP_NOP;
        cmd.seed_idx = cnt_reg[1:0] + 2'd1;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.op = DP_PREP;
                case (status.kind)
                    KIND_RESTART:  state_next = ST_SEED_LOAD;
                    KIND_RAW:      state_next = ST_DRAW;
                    KIND_RANGE:    state_next = status.bounds_equal ? ST_FINISH : ST_DRAW;
                    KIND_PERCENT:  state_next = (status.pct_zero || status.pct_full)
                                                ? ST_FINISH : ST_DRAW;
                    KIND_WEIGHTED: state_next = ST_DRAW;
                    default:       state_next = ST_FINISH;
                endcase
            end
            ST_SEED_LOAD: begin
                cmd.op     = DP_SEED_LOAD;
                cnt_next   = '0;
                state_next = ST_SEED_STEP;
            end
            ST_SEED_STEP: begin
                cmd.op   = DP_SEED_STEP;
                cnt_next = cnt_reg + 1'b1;
                // Words one to three are filled in turn.
                if (cnt_reg[1:0] == 2'd2) begin
                    state_next = ST_FINISH;
                end
            end
            ST_DRAW: begin
                cmd.op = DP_DRAW;
                case (status.kind)
                    KIND_RANGE:    state_next = ST_MUL;
                    KIND_PERCENT:  state_next = ST_MUL;
                    KIND_WEIGHTED: state_next = ST_DIV_INIT;
                    default:       state_next = ST_FINISH;
                endcase
            end
            ST_MUL: begin
                cmd.op     = DP_MUL;
                state_next = (status.kind == KIND_RANGE) ? ST_ADD : ST_FINISH;
            end
            ST_ADD: begin
                cmd.op     = DP_ADD;
                state_next = ST_FINISH;
            end
            ST_DIV_INIT: begin
                cmd.op     = DP_DIV_INIT;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op   = DP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // The result register is written only once the previous
                // request has left it.
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = DP_RESULT;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/xorshift_random_with_ranges.sv
// ----------------------------------------------------------------------------
// xorshift_random_with_ranges
// Four-word xorshift generator with restart, raw, ranged, percent and
// weighted draws. One result per request.
// ----------------------------------------------------------------------------
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------------
//  input    | s_valid / s_ready     | s_kind, s_first_operand, s_second_operand
//  result   | m_valid / m_ready     | m_value, m_occurs
//  config   | cfg_valid / cfg_ready | cfg_seed_value
//
//  A request is loaded and decoded; a draw steps the generator, ranged and
//  percent draws go on through the multiplier, a restart takes one step per
//  seeded word and a weighted draw runs the one-bit-per-cycle remainder unit.
//  Requests are handled one at a time; a finished result may wait in the
//  output register while the next request is accepted. Reset clears the
//  generator words and the seed. cfg_ready is always high.
// ----------------------------------------------------------------------------
module xorshift_random_with_ranges (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [31:0] s_first_operand,
    input  logic [31:0] s_second_operand,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic        m_occurs,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_seed_value
);
    import xrr_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    xrr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    xrr_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_seed_value    (cfg_seed_value),
        .in_kind           (s_kind),
        .in_first_operand  (s_first_operand),
        .in_second_operand (s_second_operand),
        .out_value         (m_value),
        .out_occurs        (m_occurs)
    );

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the xorshift random block. A short table of
// directed requests covers a restart on the reset seed, span extremes, the
// no-draw percent and range cases, weight clamping and the unused kind codes.
// It is followed by phases of random requests, each one opened by a seed
// write and a restart. Every result is checked against a model of the
// generator that is kept in step with the accepted requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import xrr_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 10;
    localparam int TAIL_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int N_PHASES        = 10;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int N_DIRECTED      = 24;

    // Kind codes the block does not define; they must come back as all zero.
    localparam logic [2:0] KIND_UNDEF_5 = 3'd5;
    localparam logic [2:0] KIND_UNDEF_6 = 3'd6;
    localparam logic [2:0] KIND_UNDEF_7 = 3'd7;

    localparam logic [31:0] HALVING_ABOVE  = 32'd100;
    localparam logic [31:0] PERCENT_ALWAYS = 32'd100;
    localparam logic [31:0] PERCENT_SCALE  = 32'd100;
    localparam logic [7:0]  WEIGHT_FLOOR   = 8'd1;
    localparam logic [7:0]  WEIGHT_CEIL    = 8'd99;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] value;
        logic        occurs;
    } result_t;

    // A pinned row carries a result typed in by hand instead of the model's.
    typedef struct packed {
        logic        pinned;
        logic [31:0] value;
        logic        occurs;
    } pin_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] first;
        logic [31:0] second;
        pin_t        pin;
    } stim_row_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_RARELY,
        RDY_PERIODIC
    } ready_mode_t;

    localparam pin_t NO_PIN = '{1'b0, 32'h0, 1'b0};

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{KIND_RAW,      32'h0,        32'h0,        '{1'b1, 32'h0, 1'b0}},
        '{KIND_RESTART,  ALL_ONES,     ALL_ONES,     '{1'b1, 32'h0, 1'b0}},
        '{KIND_RAW,      32'h0,        32'h0,        NO_PIN},
        '{KIND_RANGE,    32'h0,        ALL_ONES,     NO_PIN},
        '{KIND_RANGE,    ALL_ONES,     32'h0,        NO_PIN},
        '{KIND_RANGE,    32'd5,        32'd5,        '{1'b1, 32'd5, 1'b0}},
        '{KIND_RANGE,    32'h0,        32'h0,        '{1'b1, 32'h0, 1'b0}},
        '{KIND_RANGE,    ALL_ONES,     ALL_ONES,     '{1'b1, ALL_ONES, 1'b0}},
        '{KIND_RANGE,    32'd1000,     32'd3,        NO_PIN},
        '{KIND_PERCENT,  32'h0,        ALL_ONES,     '{1'b1, 32'h0, 1'b0}},
        '{KIND_PERCENT,  32'd100,      32'h0,        '{1'b1, 32'h0, 1'b1}},
        '{KIND_PERCENT,  ALL_ONES,     32'h0,        '{1'b1, 32'h0, 1'b1}},
        '{KIND_PERCENT,  32'd1,        32'h0,        NO_PIN},
        '{KIND_PERCENT,  32'd99,       32'h0,        NO_PIN},
        '{KIND_PERCENT,  32'd50,       32'h0,        NO_PIN},
        '{KIND_WEIGHTED, 32'h0,        32'h0,        NO_PIN},
        '{KIND_WEIGHTED, ALL_ONES,     ALL_ONES,     NO_PIN},
        '{KIND_WEIGHTED, 32'd1,        32'd99,       NO_PIN},
        '{KIND_WEIGHTED, 32'd99,       32'd1,        NO_PIN},
        '{KIND_WEIGHTED, 32'd100,      32'h0,        NO_PIN},
        '{KIND_UNDEF_5,  ALL_ONES,     ALL_ONES,     '{1'b1, 32'h0, 1'b0}},
        '{KIND_UNDEF_6,  32'h1234_5678, 32'h0,       '{1'b1, 32'h0, 1'b0}},
        '{KIND_UNDEF_7,  32'h0,        32'h0,        '{1'b1, 32'h0, 1'b0}},
        '{KIND_RAW,      ALL_ONES,     ALL_ONES,     NO_PIN}
    };

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [2:0]  s_kind           = KIND_RESTART;
    logic [31:0] s_first_operand  = 32'h0;
    logic [31:0] s_second_operand = 32'h0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [31:0] m_value;
    logic        m_occurs;
    logic        cfg_valid        = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_seed_value   = 32'h0;

    // Model copy of the generator and its seed register.
    logic [31:0] gen_words [4] = '{32'h0, 32'h0, 32'h0, 32'h0};
    logic [31:0] seed_word     = 32'h0;

    result_t     expected_q [$];
    pin_t        pin_q [$];
    int          fail_count  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    ready_mode_t ready_mode  = RDY_ALWAYS;
    int          ready_hold  = 0;
    int          ready_tick  = 0;

    xorshift_random_with_ranges dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_first_operand  (s_first_operand),
        .s_second_operand (s_second_operand),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_value          (m_value),
        .m_occurs         (m_occurs),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_seed_value   (cfg_seed_value)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [31:0] step_generator();
        logic [31:0] t;
        logic [31:0] top;
        t            = gen_words[0] ^ (gen_words[0] << XS_SHIFT_A);
        top          = gen_words[3];
        gen_words[0] = gen_words[1];
        gen_words[1] = gen_words[2];
        gen_words[2] = top;
        gen_words[3] = (top ^ (top >> XS_SHIFT_B)) ^ (t ^ (t >> XS_SHIFT_C));
        return gen_words[3];
    endfunction

    function automatic logic [7:0] clamp_to_weight(input logic [31:0] w);
        if (w < {24'd0, WEIGHT_FLOOR}) return WEIGHT_FLOOR;
        if (w > {24'd0, WEIGHT_CEIL}) return WEIGHT_CEIL;
        return w[7:0];
    endfunction

    function automatic result_t predict_result(input logic [2:0] kind,
                                               input logic [31:0] a,
                                               input logic [31:0] b);
        result_t     r;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] w;
        logic [31:0] rem;
        logic [32:0] span;
        logic [64:0] prod;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [7:0]  wa;
        logic [7:0]  wb;
        r = '0;
        case (kind)
            KIND_RESTART: begin
                gen_words[0] = seed_word;
                if (seed_word > HALVING_ABOVE) begin
                    gen_words[1] = seed_word / 2 - 32'd1;
                    gen_words[2] = gen_words[1] / 2 - 32'd3;
                    gen_words[3] = gen_words[2] / 2 - 32'd8;
                end else begin
                    gen_words[1] = seed_word * 2 + 32'd1;
                    gen_words[2] = gen_words[1] * 2 + 32'd3;
                    gen_words[3] = gen_words[2] * 2 + 32'd8;
                end
            end
            KIND_RAW: begin
                r.value = step_generator();
            end
            KIND_RANGE: begin
                if (a == b) begin
                    r.value = a;
                end else begin
                    lo      = (a < b) ? a : b;
                    hi      = (a < b) ? b : a;
                    span    = {1'b0, hi - lo} + 33'd1;
                    w       = step_generator();
                    prod    = 65'(w) * 65'(span);
                    r.value = lo + prod[63:32];
                end
            end
            KIND_PERCENT: begin
                if (a == 32'h0) begin
                    r.occurs = 1'b0;
                end else if (a >= PERCENT_ALWAYS) begin
                    r.occurs = 1'b1;
                end else begin
                    w        = step_generator();
                    lhs      = 64'(w) * 64'(PERCENT_SCALE);
                    rhs      = 64'(a) * 64'(ALL_ONES);
                    r.occurs = (lhs <= rhs);
                end
            end
            KIND_WEIGHTED: begin
                wa       = clamp_to_weight(a);
                wb       = clamp_to_weight(b);
                w        = step_generator();
                rem      = w % {24'd0, wa + wb};
                r.occurs = (rem + 32'd1 <= {24'd0, wa});
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return ALL_ONES;
            2, 3, 4: return $urandom_range(0, 120);
            default: return $urandom;
        endcase
    endfunction

    // Present one request and hold it until accepted. Bursts end with a
    // random gap in which valid is low.
    task automatic send_request(input logic [2:0] kind, input logic [31:0] a,
                                input logic [31:0] b, input pin_t pin);
        int gap;
        pin_q.push_back(pin);
        s_valid          <= 1'b1;
        s_kind           <= kind;
        s_first_operand  <= a;
        s_second_operand <= b;
        do @(posedge aclk); while (!s_ready);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 20);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_q.size() != 0);
    endtask

    // Receiver stall pattern: the mode is redrawn at random once its hold count runs out.
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (ready_hold == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            ready_hold <= $urandom_range(20, 200);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            RDY_ALWAYS:   m_ready <= 1'b1;
            RDY_MOSTLY:   m_ready <= ($urandom_range(0, 3) != 0);
            RDY_RARELY:   m_ready <= ($urandom_range(0, 3) == 0);
            default:      m_ready <= ((ready_tick % 8) < 5);
        endcase
    end

    // Monitor: seed writes and accepted requests feed the model, results
    // are checked against the oldest expectation.
    always @(posedge aclk) begin
        result_t r;
        pin_t    pin;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                seed_word = cfg_seed_value;
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with no request pending: value %h occurs %b",
                             $time, m_value, m_occurs);
                    fail_count++;
                end else begin
                    r = expected_q.pop_front();
                    if (m_value !== r.value) begin
                        $display("%0t: value mismatch: expected %h, actual %h",
                                 $time, r.value, m_value);
                        fail_count++;
                    end
                    if (m_occurs !== r.occurs) begin
                        $display("%0t: occurs mismatch: expected %b, actual %b",
                                 $time, r.occurs, m_occurs);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                r   = predict_result(s_kind, s_first_operand, s_second_operand);
                pin = pin_q.pop_front();
                if (pin.pinned) begin
                    r.value  = pin.value;
                    r.occurs = pin.occurs;
                end
                expected_q.push_back(r);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int          counted;
        int          pick;
        logic [2:0]  kind;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] seed;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The first rows run on the seed left by reset.
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(DIRECTED[i].kind, DIRECTED[i].first, DIRECTED[i].second,
                         DIRECTED[i].pin);
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            // The seed is only written with no request in flight.
            drain_results();
            case (phase)
                0:       seed = ALL_ONES;
                1:       seed = HALVING_ABOVE;
                2:       seed = HALVING_ABOVE + 32'd1;
                3:       seed = 32'h0;
                4:       seed = 32'd1;
                default: seed = ($urandom_range(0, 1) == 0) ? $urandom
                                                            : $urandom_range(0, 200);
            endcase
            cfg_valid      <= 1'b1;
            cfg_seed_value <= seed;
            do @(posedge aclk); while (!cfg_ready);
            cfg_valid <= 1'b0;

            send_request(KIND_RESTART, $urandom, $urandom, NO_PIN);
            counted = 1;
            while (counted < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    kind = KIND_RESTART;
                end else if (pick < 22) begin
                    kind = KIND_RAW;
                end else if (pick < 46) begin
                    kind = KIND_RANGE;
                end else if (pick < 68) begin
                    kind = KIND_PERCENT;
                end else if (pick < 93) begin
                    kind = KIND_WEIGHTED;
                end else begin
                    case ($urandom_range(0, 2))
                        0:       kind = KIND_UNDEF_5;
                        1:       kind = KIND_UNDEF_6;
                        default: kind = KIND_UNDEF_7;
                    endcase
                end
                a = rand_operand();
                b = rand_operand();
                case (kind)
                    KIND_RANGE: begin
                        pick = $urandom_range(0, 9);
                        if (pick == 0) begin
                            b = a;
                        end else if (pick < 4) begin
                            b = a + $urandom_range(1, 64);
                        end
                    end
                    KIND_PERCENT: begin
                        if ($urandom_range(0, 9) < 7) a = $urandom_range(0, 110);
                    end
                    KIND_WEIGHTED: begin
                        if ($urandom_range(0, 9) < 7) a = $urandom_range(0, 110);
                        if ($urandom_range(0, 9) < 7) b = $urandom_range(0, 110);
                    end
                    default: begin
                    end
                endcase
                send_request(kind, a, b, NO_PIN);
                if (kind <= KIND_WEIGHTED) counted++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/xrr_pkg.sv
rtl/xrr_datapath.sv
rtl/xrr_ctrl.sv
rtl/xorshift_random_with_ranges.sv
test/tb.sv
